### hw/rtl/blras_pkg.sv
// ----------------------------------------------------------------------------
// blras_pkg
// Shared types, constants and modular helpers for the lazy range add/sum block.
// ----------------------------------------------------------------------------
package blras_pkg;

   localparam int DATA_W = 30;
   localparam int REQ_IDX_W = 10;

   localparam logic [DATA_W-1:0] MOD_P = 30'd1000000007;

   localparam int NUM_ELEMENTS_DEF = 1024;
   localparam int BLOCK_SIZE_DEF = 32;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUM = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PREP,
      ST_SETUP,
      ST_ISSUE,
      ST_EXEC,
      ST_FINISH
   } blras_state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic prep;
      logic setup;
      logic exec;
      logic load_rsp;
   } blras_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic prep_last;
      logic walk_more;
      logic is_query;
   } blras_status_type;

   function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MOD_P}) begin
         s = s - {1'b0, MOD_P};
      end
      return s[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] mod_add3(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] c);
      logic [DATA_W+1:0] s;
      logic [DATA_W+1:0] p1;
      logic [DATA_W+1:0] p2;
      p1 = {2'b00, MOD_P};
      p2 = {1'b0, MOD_P, 1'b0};
      s = {2'b00, a} + {2'b00, b} + {2'b00, c};
      if (s >= p2) begin
         s = s - p2;
      end else if (s >= p1) begin
         s = s - p1;
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

### hw/rtl/block_lazy_range_add_sum_mod_top.sv
// ----------------------------------------------------------------------------
// block_lazy_range_add_sum_mod_top
// Range add / range sum modulo 1000000007 over blocks with lazy adds.
// One request at a time; each request walks S steps, where
// S = edge elements plus whole blocks visited (at most 2*(BLOCK_SIZE-1) +
// NUM_ELEMENTS/BLOCK_SIZE); each step reads the stores and, for an add, updates them.
// A sum result is loaded into the output register in finish;
// a sum holds in finish while the previous result is unread.
// After reset a clearing pass over the NUM_ELEMENTS elements runs with req_ready low.
// ----------------------------------------------------------------------------
module block_lazy_range_add_sum_mod_top #(
   parameter int NUM_ELEMENTS = blras_pkg::NUM_ELEMENTS_DEF,
   parameter int BLOCK_SIZE = blras_pkg::BLOCK_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [blras_pkg::REQ_IDX_W-1:0] req_range_lo,
   input  logic [blras_pkg::REQ_IDX_W-1:0] req_range_hi,
   input  logic [blras_pkg::DATA_W-1:0]    req_add_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [blras_pkg::DATA_W-1:0]    rsp_range_sum
);

   blras_pkg::blras_cmd_type    cmd;
   blras_pkg::blras_status_type status;

   blras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   blras_dp #(
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .BLOCK_SIZE   (BLOCK_SIZE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_range_lo  (req_range_lo),
      .req_range_hi  (req_range_hi),
      .req_add_value (req_add_value),
      .rsp_range_sum (rsp_range_sum)
   );

endmodule

### hw/rtl/blras_ram.sv
// ----------------------------------------------------------------------------
// blras_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blras_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/blras_ctrl.sv
// ----------------------------------------------------------------------------
// blras_ctrl
// Sequencer: clearing pass, request capture, preparation, setup, element/block walk, result.
// ----------------------------------------------------------------------------
module blras_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output blras_pkg::blras_cmd_type   cmd,
   input  blras_pkg::blras_status_type status
);

   blras_pkg::blras_state_type state_ff;
   blras_pkg::blras_state_type state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blras_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         blras_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = blras_pkg::ST_IDLE;
            end
         end
         blras_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = blras_pkg::ST_PREP;
            end
         end
         blras_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            if (status.prep_last) begin
               state_in = blras_pkg::ST_SETUP;
            end
         end
         blras_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in = blras_pkg::ST_ISSUE;
         end
         blras_pkg::ST_ISSUE: begin
            if (status.walk_more) begin
               state_in = blras_pkg::ST_EXEC;
            end else begin
               state_in = blras_pkg::ST_FINISH;
            end
         end
         blras_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = blras_pkg::ST_ISSUE;
         end
         blras_pkg::ST_FINISH: begin
            if (!status.is_query) begin
               state_in = blras_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in = blras_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blras_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_exec_after_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == blras_pkg::ST_EXEC |-> $past(state_ff) == blras_pkg::ST_ISSUE)
      else $error("walk step executed without a preceding read");

   a_accept_starts_prep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == blras_pkg::ST_PREP)
      else $error("accepted request did not start preparation");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == blras_pkg::ST_FINISH)
      else $error("result raised outside of finish");

endmodule

### hw/rtl/blras_dp.sv
// ----------------------------------------------------------------------------
// blras_dp
// Datapath: element and block stores, block locate by reciprocal multiply,
// block increment multiplier, walk index tracking and modular accumulation.
// ----------------------------------------------------------------------------
module blras_dp #(
   parameter int NUM_ELEMENTS = blras_pkg::NUM_ELEMENTS_DEF,
   parameter int BLOCK_SIZE = blras_pkg::BLOCK_SIZE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  blras_pkg::blras_cmd_type            cmd,
   output blras_pkg::blras_status_type         status,
   input  logic                                req_op,
   input  logic [blras_pkg::REQ_IDX_W-1:0]     req_range_lo,
   input  logic [blras_pkg::REQ_IDX_W-1:0]     req_range_hi,
   input  logic [blras_pkg::DATA_W-1:0]        req_add_value,
   output logic [blras_pkg::DATA_W-1:0]        rsp_range_sum
);

   localparam int DW = blras_pkg::DATA_W;
   localparam int QW = blras_pkg::REQ_IDX_W;
   localparam int NB = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int LAST_CNT = NUM_ELEMENTS - (NB - 1) * BLOCK_SIZE;
   localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int BW = (NB > 1) ? $clog2(NB) : 1;
   localparam int IW_RAW = $clog2(NUM_ELEMENTS + BLOCK_SIZE);
   localparam int CW = (IW_RAW > QW) ? IW_RAW : QW;
   localparam int CNTW = $clog2(BLOCK_SIZE + 1);
   localparam int SW = $clog2(QW);
   localparam int LOG_BS = $clog2(BLOCK_SIZE);
   localparam int RSH = QW + LOG_BS;
   localparam int RCP_W = QW + 2;
   localparam int LW = QW + RCP_W;
   localparam int QB = LW - RSH;

   localparam logic [CW-1:0] N_C = CW'(NUM_ELEMENTS);
   localparam logic [CW-1:0] N_M1_C = CW'(NUM_ELEMENTS - 1);
   localparam logic [CW-1:0] BS_C = CW'(BLOCK_SIZE);
   localparam logic [LW-1:0] RCP_L = LW'(((1 << RSH) + BLOCK_SIZE - 1) / BLOCK_SIZE);

   // request and walk registers
   logic            op_ff;
   logic [DW-1:0]   val_ff;
   logic [CW-1:0]   hi_ff;
   logic [CW-1:0]   i_ff;
   logic [CW-1:0]   bstart_ff;
   logic [BW-1:0]   blk_ff;
   logic [DW-1:0]   acc_ff;
   logic [DW-1:0]   rsp_sum_ff;
   // preparation units
   logic [SW-1:0]   step_ff;
   logic [DW-1:0]   dbl_ff;
   logic [DW-1:0]   inc_full_ff;
   logic [DW-1:0]   inc_last_ff;
   logic [CNTW-1:0] cnt_full_ff;
   logic [CNTW-1:0] cnt_last_ff;
   // clearing pass
   logic [AW-1:0]   clr_ff;

   logic [DW-1:0] val_red;
   logic [CW-1:0] hi_ext;
   logic [LW-1:0] loc_prod;
   logic [QB-1:0] loc_blk;
   logic          is_sum;
   logic [CW-1:0] nb;
   logic [CW-1:0] bend_p1;
   logic [CW-1:0] i_next;
   logic          whole;
   logic          blk_step;
   logic [DW-1:0] inc;
   logic          clr_blk;

   logic          elem_we;
   logic [AW-1:0] elem_addr;
   logic [DW-1:0] elem_wdata;
   logic [DW-1:0] elem_rd;
   logic          lazy_we;
   logic [BW-1:0] blk_addr;
   logic [DW-1:0] lazy_wdata;
   logic [DW-1:0] lazy_rd;
   logic          sum_we;
   logic [DW-1:0] sum_wdata;
   logic [DW-1:0] sum_rd;

   assign val_red = (req_add_value >= blras_pkg::MOD_P) ?
                    req_add_value - blras_pkg::MOD_P : req_add_value;
   assign hi_ext = CW'(req_range_hi);

   assign loc_prod = LW'(i_ff[QW-1:0]) * RCP_L;
   assign loc_blk = loc_prod[LW-1:RSH];
   assign is_sum = op_ff == blras_pkg::OP_SUM;

   assign nb = bstart_ff + BS_C;
   assign bend_p1 = (nb > N_C) ? N_C : nb;
   assign i_next = i_ff + CW'(1);
   assign whole = (i_ff == bstart_ff) && ((bend_p1 - CW'(1)) <= hi_ff);
   assign blk_step = whole || (i_next == bend_p1);
   assign inc = (blk_ff == BW'(NB - 1)) ? inc_last_ff : inc_full_ff;
   assign clr_blk = clr_ff < AW'(NB);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         val_ff <= val_red;
         hi_ff <= (hi_ext > N_M1_C) ? N_M1_C : hi_ext;
         i_ff <= CW'(req_range_lo);
         step_ff <= '0;
         dbl_ff <= val_red;
         inc_full_ff <= '0;
         inc_last_ff <= '0;
         cnt_full_ff <= CNTW'(BLOCK_SIZE);
         cnt_last_ff <= CNTW'(LAST_CNT);
         acc_ff <= '0;
      end
      if (cmd.prep) begin
         step_ff <= step_ff + SW'(1);
         if (cnt_full_ff[0]) begin
            inc_full_ff <= blras_pkg::mod_add(inc_full_ff, dbl_ff);
         end
         if (cnt_last_ff[0]) begin
            inc_last_ff <= blras_pkg::mod_add(inc_last_ff, dbl_ff);
         end
         dbl_ff <= blras_pkg::mod_add(dbl_ff, dbl_ff);
         cnt_full_ff <= cnt_full_ff >> 1;
         cnt_last_ff <= cnt_last_ff >> 1;
      end
      if (cmd.setup) begin
         blk_ff <= BW'(loc_blk);
         bstart_ff <= CW'(loc_blk) * BS_C;
      end
      if (cmd.exec) begin
         i_ff <= whole ? bend_p1 : i_next;
         if (blk_step) begin
            blk_ff <= blk_ff + BW'(1);
            bstart_ff <= bend_p1;
         end
         if (is_sum) begin
            if (whole) begin
               acc_ff <= blras_pkg::mod_add(acc_ff, sum_rd);
            end else begin
               acc_ff <= blras_pkg::mod_add3(acc_ff, elem_rd, lazy_rd);
            end
         end
      end
      if (cmd.load_rsp) begin
         rsp_sum_ff <= acc_ff;
      end
   end

   assign elem_addr = cmd.clear ? clr_ff : i_ff[AW-1:0];
   assign elem_we = cmd.clear || (cmd.exec && !is_sum && !whole);
   assign elem_wdata = cmd.clear ? DW'(1) : blras_pkg::mod_add(elem_rd, val_ff);

   assign blk_addr = cmd.clear ? clr_ff[BW-1:0] : blk_ff;
   assign lazy_we = (cmd.clear && clr_blk) || (cmd.exec && !is_sum && whole);
   assign lazy_wdata = cmd.clear ? '0 : blras_pkg::mod_add(lazy_rd, val_ff);
   assign sum_we = (cmd.clear && clr_blk) || (cmd.exec && !is_sum);

   always_comb begin
      if (cmd.clear) begin
         sum_wdata = (clr_ff == AW'(NB - 1)) ? DW'(LAST_CNT) : DW'(BLOCK_SIZE);
      end else begin
         sum_wdata = blras_pkg::mod_add(sum_rd, whole ? inc : val_ff);
      end
   end

   blras_ram #(.WIDTH(DW), .DEPTH(NUM_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_addr),
      .wr_data (elem_wdata),
      .rd_addr (elem_addr),
      .rd_data (elem_rd)
   );

   blras_ram #(.WIDTH(DW), .DEPTH(NB)) u_lazy_ram (
      .clock   (clock),
      .wr_en   (lazy_we),
      .wr_addr (blk_addr),
      .wr_data (lazy_wdata),
      .rd_addr (blk_addr),
      .rd_data (lazy_rd)
   );

   blras_ram #(.WIDTH(DW), .DEPTH(NB)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (blk_addr),
      .wr_data (sum_wdata),
      .rd_addr (blk_addr),
      .rd_data (sum_rd)
   );

   assign status.clear_last = clr_ff == AW'(NUM_ELEMENTS - 1);
   assign status.prep_last = step_ff == SW'(QW - 1);
   assign status.walk_more = i_ff <= hi_ff;
   assign status.is_query = is_sum;

   assign rsp_range_sum = rsp_sum_ff;

   a_exec_in_block: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (i_ff >= bstart_ff) && (i_ff < bend_p1))
      else $error("walk index outside its tracked block");

   a_setup_locates_block: assert property (@(posedge clock) disable iff (reset)
      cmd.setup |=> (i_ff >= bstart_ff) && ((i_ff - bstart_ff) < BS_C))
      else $error("block locate gave a wrong block start");

endmodule
